// File: rtl/jcq_pkg.sv
// Shared constants, quantization tables and types for the JPEG coefficient quantizer.
`timescale 1ns / 1ps
`default_nettype none

package jcq_pkg;

    localparam int COEF_WIDTH      = 16;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int BLOCK_SIZE      = 8;
    localparam int IN_FRAC_BITS    = 4;
    localparam int SCALE_WIDTH     = 12;
    localparam int Q_WIDTH         = 7;
    localparam int POS_WIDTH       = 3;
    localparam int OUT_WIDTH       = 21;
    localparam int TABLE_DEPTH     = BLOCK_SIZE * BLOCK_SIZE;
    localparam int TABLE_IDX_W     = 2 * POS_WIDTH;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = ((COEF_WIDTH + 2 * POS_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OUT_WIDTH + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SCALE_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_SCALE     = 1'd1;

    localparam logic MODE_QUANTIZE   = 1'b0;
    localparam logic MODE_DEQUANTIZE = 1'b1;

    // Effective table factor: q * scale for luma, q << SCALE_FRAC_BITS for chroma
    localparam int FACT_W = Q_WIDTH + SCALE_WIDTH;
    localparam int PROD_W = COEF_WIDTH + FACT_W;
    localparam int RES_W  = PROD_W - SCALE_FRAC_BITS;

    // Rounded division: quotient = (2*num + den) / (2*den)
    localparam int NUM_A  = COEF_WIDTH + SCALE_FRAC_BITS + 1;
    localparam int NUM_B  = FACT_W + IN_FRAC_BITS;
    localparam int NUM_W  = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 1;
    localparam int DEN_W  = FACT_W + IN_FRAC_BITS + 1;
    localparam int REM_W  = DEN_W + 1;
    // Smallest nonzero divisor is 10 * 16 = 160 >= 2^7
    localparam int QUO_W  = COEF_WIDTH + SCALE_FRAC_BITS - 7;

    localparam logic [RES_W-1:0] RES_POS_LIM = RES_W'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
    localparam logic [RES_W-1:0] RES_NEG_LIM = RES_W'(64'd1 << (OUT_WIDTH - 1));
    localparam logic [OUT_WIDTH-1:0] OUT_MAX_VAL = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_MIN_VAL = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    localparam logic [Q_WIDTH-1:0] LUMA_Q [TABLE_DEPTH] = '{
        7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
        7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
        7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
        7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
        7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
        7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
        7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
        7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
    };

    localparam logic [Q_WIDTH-1:0] CHROMA_Q [TABLE_DEPTH] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic              mode;
        logic              neg;
        logic              div_zero;
        logic              mag_zero;
        logic [PROD_W-1:0] prod;
    } jcq_side_t;

endpackage

`default_nettype wire

// File: rtl/jcq_div.sv
// Elastic restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none

module jcq_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [jcq_pkg::NUM_W-1:0] in_num,
    input  wire logic [jcq_pkg::DEN_W-1:0] in_den,
    input  wire jcq_pkg::jcq_side_t        in_side,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [jcq_pkg::QUO_W-1:0]     out_quo,
    output jcq_pkg::jcq_side_t            out_side
);
    import jcq_pkg::*;

    logic              valid_reg [QUO_W];
    logic [REM_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    jcq_side_t         side_reg  [QUO_W];
    logic              rdy       [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            logic             src_valid;
            logic [REM_W-1:0] src_rem;
            logic [QUO_W-1:0] src_low;
            logic [QUO_W-1:0] src_quo;
            logic [DEN_W-1:0] src_den;
            jcq_side_t        src_side;
            logic [REM_W-1:0] trial;
            logic             ge;
            logic             down_ready;

            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                // upper bits are already below the divisor when the quotient fits
                assign src_rem   = REM_W'(in_num[NUM_W-1:QUO_W]);
                assign src_low   = in_num[QUO_W-1:0];
                assign src_quo   = '0;
                assign src_den   = in_den;
                assign src_side  = in_side;
            end
            else
            begin : g_next
                assign src_valid = valid_reg[k-1];
                assign src_rem   = rem_reg[k-1];
                assign src_low   = low_reg[k-1];
                assign src_quo   = quo_reg[k-1];
                assign src_den   = den_reg[k-1];
                assign src_side  = side_reg[k-1];
            end

            if (k == QUO_W - 1)
            begin : g_last
                assign down_ready = out_ready;
            end
            else
            begin : g_mid
                assign down_ready = rdy[k+1];
            end

            assign rdy[k] = !valid_reg[k] || down_ready;
            assign trial  = {src_rem[REM_W-2:0], src_low[QUO_W-1]};
            assign ge     = trial >= REM_W'(src_den);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    valid_reg[k] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && src_valid)
                begin
                    rem_reg[k]  <= ge ? (trial - REM_W'(src_den)) : trial;
                    low_reg[k]  <= {src_low[QUO_W-2:0], 1'b0};
                    quo_reg[k]  <= {src_quo[QUO_W-2:0], ge};
                    den_reg[k]  <= src_den;
                    side_reg[k] <= src_side;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/jpeg_coefficient_quantizer_top.sv
// Top level of the JPEG coefficient quantizer / dequantizer stream pipeline.
// Pipeline: 3 front stages, 17 divider stages and 1 output register between input
// beat and output beat. The divider retires one quotient bit per stage.
// Throughput: one beat per cycle; each stage stalls only when its successor cannot accept.
// Reset: asynchronous, active low; clears all valid bits, direction_mode to
// quantize and luma_scale to 256 (1.0).
`timescale 1ns / 1ps
`default_nettype none

module jpeg_coefficient_quantizer_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [jcq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [jcq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // coefficient[15:0], block_row[18:16], block_col[21:19], zero pad
    input  wire logic [jcq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // is_chroma[0]
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // result_value[20:0], zero pad
    output logic [jcq_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    // saturated[0]
    output logic [0:0]                             m_axis_tuser
);
    import jcq_pkg::*;

    logic                   direction_mode_reg;
    logic [SCALE_WIDTH-1:0] luma_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_mode_reg <= MODE_QUANTIZE;
            luma_scale_reg     <= SCALE_WIDTH'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECTION_MODE: direction_mode_reg <= cfg_data[0];
                REG_LUMA_SCALE:     luma_scale_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- stage 1: sign/magnitude and table lookup
    logic [COEF_WIDTH-1:0]  in_coef;
    logic [TABLE_IDX_W-1:0] in_idx;
    logic                   in_chroma;
    logic                   s1_valid_reg;
    logic                   s1_rdy;
    logic [COEF_WIDTH-1:0]  s1_mag_reg;
    logic                   s1_neg_reg;
    logic                   s1_chroma_reg;
    logic [Q_WIDTH-1:0]     s1_q_reg;

    assign in_coef   = s_axis_tdata[COEF_WIDTH-1:0];
    assign in_idx    = {s_axis_tdata[COEF_WIDTH+POS_WIDTH-1:COEF_WIDTH],
                        s_axis_tdata[COEF_WIDTH+2*POS_WIDTH-1:COEF_WIDTH+POS_WIDTH]};
    assign in_chroma = s_axis_tuser[0];

    // ---------------- stage 2: effective table factor
    logic                   s2_valid_reg;
    logic                   s2_rdy;
    logic [COEF_WIDTH-1:0]  s2_mag_reg;
    logic                   s2_neg_reg;
    logic [FACT_W-1:0]      s2_fact_reg;

    // ---------------- stage 3: product and divider operands
    logic                   s3_valid_reg;
    logic                   s3_rdy;
    logic [NUM_W-1:0]       s3_num_reg;
    logic [DEN_W-1:0]       s3_den_reg;
    jcq_side_t              s3_side_reg;

    logic                   div_in_ready;
    logic                   div_out_valid;
    logic                   div_out_ready;
    logic [QUO_W-1:0]       div_quo;
    jcq_side_t              div_side;

    logic                   out_valid_reg;
    logic [OUT_WIDTH-1:0]   result_reg;
    logic                   sat_reg;

    assign s3_rdy        = !s3_valid_reg || div_in_ready;
    assign s2_rdy        = !s2_valid_reg || s3_rdy;
    assign s1_rdy        = !s1_valid_reg || s2_rdy;
    assign s_axis_tready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_rdy)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_rdy)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && s_axis_tvalid)
        begin
            s1_neg_reg    <= in_coef[COEF_WIDTH-1];
            // two's complement of the most negative value reads correctly as unsigned
            s1_mag_reg    <= in_coef[COEF_WIDTH-1] ? (~in_coef + 1'b1) : in_coef;
            s1_chroma_reg <= in_chroma;
            s1_q_reg      <= in_chroma ? CHROMA_Q[in_idx] : LUMA_Q[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_valid_reg)
        begin
            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
            if (s1_chroma_reg)
            begin
                s2_fact_reg <= {{(FACT_W-Q_WIDTH-SCALE_FRAC_BITS){1'b0}}, s1_q_reg,
                                {SCALE_FRAC_BITS{1'b0}}};
            end
            else
            begin
                s2_fact_reg <= FACT_W'(s1_q_reg) * FACT_W'(luma_scale_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && s2_valid_reg)
        begin
            // num = mag << SCALE_FRAC_BITS, den = fact << IN_FRAC_BITS; the registers hold 2*num + den and 2*den
            s3_num_reg <= NUM_W'({s2_mag_reg, {(SCALE_FRAC_BITS+1){1'b0}}})
                        + NUM_W'({s2_fact_reg, {IN_FRAC_BITS{1'b0}}});
            s3_den_reg <= {s2_fact_reg, {(IN_FRAC_BITS+1){1'b0}}};
            s3_side_reg.mode     <= direction_mode_reg;
            s3_side_reg.neg      <= s2_neg_reg;
            s3_side_reg.div_zero <= (s2_fact_reg == '0);
            s3_side_reg.mag_zero <= (s2_mag_reg == '0);
            s3_side_reg.prod     <= PROD_W'(s2_mag_reg) * PROD_W'(s2_fact_reg);
        end
    end

    jcq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_num    (s3_num_reg),
        .in_den    (s3_den_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // ---------------- output stage: select, sign and saturate
    logic [RES_W-1:0]     res_mag;
    logic [RES_W-1:0]     res_neg;
    logic                 neg_eff;
    logic [OUT_WIDTH-1:0] result_next;
    logic                 sat_next;

    assign res_mag = (div_side.mode == MODE_DEQUANTIZE)
                   ? div_side.prod[PROD_W-1:SCALE_FRAC_BITS]
                   : RES_W'(div_quo);
    assign res_neg = RES_W'(0) - res_mag;
    assign neg_eff = div_side.neg && (res_mag != '0);

    always_comb
    begin
        result_next = res_mag[OUT_WIDTH-1:0];
        sat_next    = 1'b0;
        if (div_side.mode == MODE_QUANTIZE && div_side.div_zero)
        begin
            // zero luma scale: a zero coefficient gives zero, else clip to the signed extreme
            if (div_side.mag_zero)
            begin
                result_next = '0;
            end
            else
            begin
                result_next = div_side.neg ? OUT_MIN_VAL : OUT_MAX_VAL;
                sat_next    = 1'b1;
            end
        end
        else if (neg_eff)
        begin
            if (res_mag > RES_NEG_LIM)
            begin
                result_next = OUT_MIN_VAL;
                sat_next    = 1'b1;
            end
            else
            begin
                result_next = res_neg[OUT_WIDTH-1:0];
            end
        end
        else if (res_mag > RES_POS_LIM)
        begin
            result_next = OUT_MAX_VAL;
            sat_next    = 1'b1;
        end
    end

    assign div_out_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready && div_out_valid)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_WIDTH){1'b0}}, result_reg};
    assign m_axis_tuser  = sat_reg;

endmodule

`default_nettype wire
